@@ hw/rtl/mmcal_pkg.sv @@
// Shared types and constants for the magnetometer min/max calibrator.
package mmcal_pkg;

    localparam int AXES    = 3;
    localparam int RAW_W   = 16;
    localparam int SUM_W   = RAW_W + 1;
    localparam int RANGE_W = 16;
    localparam int OUT_W   = 32;
    localparam int CMD_W   = 2;

    typedef logic signed [RAW_W-1:0] raw_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [RANGE_W-1:0]      range_t;
    typedef logic signed [OUT_W-1:0] corr_t;
    typedef logic [CMD_W-1:0]        cmd_t;

    localparam cmd_t CMD_SAMPLE = 2'd0;
    localparam cmd_t CMD_START  = 2'd1;
    localparam cmd_t CMD_FINISH = 2'd2;

    localparam raw_t   MIN_RESET   = 16'sh7FFF;
    localparam raw_t   MAX_RESET   = -16'sh8000;
    localparam range_t RANGE_RESET = 16'd2;
    localparam range_t LIMIT_RESET = 16'd10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_DONE
    } state_t;

    // How the corrected fields of a result are formed.
    typedef enum logic [1:0] {
        KIND_ZERO,
        KIND_RAW,
        KIND_CORR
    } kind_t;

endpackage

@@ hw/rtl/mmcal_item_if.sv @@
// Input channel: command and raw three-axis sample.
interface mmcal_item_if;
    logic              valid;
    logic              ready;
    mmcal_pkg::cmd_t   cmd;
    mmcal_pkg::raw_t   raw_x;
    mmcal_pkg::raw_t   raw_y;
    mmcal_pkg::raw_t   raw_z;

    modport source (output valid, output cmd, output raw_x, output raw_y, output raw_z,
                    input ready);
    modport sink   (input valid, input cmd, input raw_x, input raw_y, input raw_z,
                    output ready);
endinterface

@@ hw/rtl/mmcal_result_if.sv @@
// Output channel: corrected sample and calibration flags.
interface mmcal_result_if;
    logic             valid;
    logic             ready;
    mmcal_pkg::corr_t corrected_x;
    mmcal_pkg::corr_t corrected_y;
    mmcal_pkg::corr_t corrected_z;
    logic             new_extreme;
    logic             calibrating;
    logic             cal_failed;

    modport source (output valid, output corrected_x, output corrected_y, output corrected_z,
                    output new_extreme, output calibrating, output cal_failed,
                    input ready);
    modport sink   (input valid, input corrected_x, input corrected_y, input corrected_z,
                    input new_extreme, input calibrating, input cal_failed,
                    output ready);
endinterface

@@ hw/rtl/mmcal_div.sv @@
// Bit-serial restoring divider: one quotient bit per cycle, unsigned.
module mmcal_div #(
    parameter int DIVD_W = 29
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [DIVD_W-1:0]         dividend,
    input  mmcal_pkg::range_t         divisor,
    output logic                      busy,
    output logic [DIVD_W-1:0]         quotient
);

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic [CNT_W-1:0]                     cnt_reg, cnt_next;
    logic [DIVD_W-1:0]                    dq_reg, dq_next;
    mmcal_pkg::range_t                    rem_reg, rem_next;
    mmcal_pkg::range_t                    dvs_reg, dvs_next;
    logic [mmcal_pkg::RANGE_W:0]          trial;
    logic [mmcal_pkg::RANGE_W:0]          trial_sub;
    logic                                 fits;

    // Bring down the next dividend bit and try the subtract.
    assign trial     = {rem_reg, dq_reg[DIVD_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next = cnt_reg;
        dq_next  = dq_reg;
        rem_next = rem_reg;
        dvs_next = dvs_reg;
        if (start)
        begin
            cnt_next = CNT_W'(DIVD_W);
            dq_next  = dividend;
            rem_next = '0;
            dvs_next = divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - 1'b1;
            dq_next  = {dq_reg[DIVD_W-2:0], fits};
            rem_next = fits ? trial_sub[mmcal_pkg::RANGE_W-1:0]
                            : trial[mmcal_pkg::RANGE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dq_reg  <= dq_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = dq_reg;

endmodule

@@ hw/rtl/magnetometer_min_max_calibrator.sv @@
// Top level: hard-iron min/max calibration and per-axis correction of magnetometer samples.
//
//   channel    dir   handshake        beat contents
//   item       in    valid/ready      cmd, raw_x, raw_y, raw_z
//   result     out   valid/ready      corrected_x/y/z, new_extreme, calibrating, cal_failed
//   cfg        in    cfg_we           cfg_wdata -> stability limit
//
// Commands, and samples taken while calibrating, pass from the idle state to the done state.
// A sample outside calibration also passes through the divide state, whose length is
// set by the three bit-serial dividers that run side by side, one quotient bit a cycle.
// One item is in flight at a time; the next is taken while the last result waits in the
// output register, and a stalled result holds the block in its done state.
// Reset restores the limit, extremes, offsets and scales at once; there is no clearing pass.
module magnetometer_min_max_calibrator #(
    parameter int FRAC_BITS = 12
) (
    input  logic                     clk,
    input  logic                     rst_n,
    mmcal_item_if.sink               item,
    mmcal_result_if.source           result,
    input  logic                     cfg_we,
    input  mmcal_pkg::range_t        cfg_wdata
);

    localparam int AX    = mmcal_pkg::AXES;
    localparam int MAG_W = mmcal_pkg::SUM_W + FRAC_BITS;
    localparam int QX_W  = (MAG_W > mmcal_pkg::OUT_W) ? MAG_W : mmcal_pkg::OUT_W;

    mmcal_pkg::state_t   state_reg, state_next;
    mmcal_pkg::kind_t    kind_reg, kind_next;
    logic                cal_active_reg, cal_active_next;
    logic                ext_reg, ext_next;
    logic                fail_reg, fail_next;
    mmcal_pkg::range_t   limit_reg, limit_next;

    mmcal_pkg::raw_t     last_reg [AX];
    mmcal_pkg::raw_t     last_next [AX];
    mmcal_pkg::raw_t     min_reg [AX];
    mmcal_pkg::raw_t     min_next [AX];
    mmcal_pkg::raw_t     max_reg [AX];
    mmcal_pkg::raw_t     max_next [AX];
    mmcal_pkg::sum_t     sum_reg [AX];
    mmcal_pkg::sum_t     sum_next [AX];
    mmcal_pkg::range_t   range_reg [AX];
    mmcal_pkg::range_t   range_next [AX];

    mmcal_pkg::raw_t     raw_in [AX];
    mmcal_pkg::raw_t     raw_hold_reg [AX];
    logic                neg_reg [AX];
    logic                zero_reg [AX];

    mmcal_pkg::corr_t    corr_reg [AX];
    mmcal_pkg::corr_t    corr_calc [AX];
    logic                res_valid_reg;
    logic                ext_out_reg;
    logic                cal_out_reg;
    logic                fail_out_reg;

    logic signed [mmcal_pkg::SUM_W-1:0]  delta [AX];
    logic [mmcal_pkg::SUM_W-1:0]         delta_mag [AX];
    logic [AX-1:0]                       near;
    logic signed [mmcal_pkg::SUM_W-1:0]  span [AX];
    logic signed [mmcal_pkg::SUM_W-1:0]  psum [AX];
    logic [AX-1:0]                       span_ok;
    logic signed [mmcal_pkg::SUM_W:0]    num [AX];
    logic [mmcal_pkg::SUM_W-1:0]         num_mag [AX];
    logic [MAG_W-1:0]                    dividend [AX];
    logic [MAG_W-1:0]                    div_q [AX];
    logic [QX_W-1:0]                     qx [AX];
    logic [AX-1:0]                       div_busy;

    logic                accept;
    logic                div_start;
    logic                load_res;
    logic                steady;
    logic                fail_now;

    assign raw_in[0] = item.raw_x;
    assign raw_in[1] = item.raw_y;
    assign raw_in[2] = item.raw_z;

    assign item.ready = (state_reg == mmcal_pkg::ST_IDLE);
    assign accept     = item.valid && item.ready;

    // Per-axis datapath: stability check, extremes, and the correction numerator.
    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            delta[i]     = {raw_in[i][mmcal_pkg::RAW_W-1], raw_in[i]}
                         - {last_reg[i][mmcal_pkg::RAW_W-1], last_reg[i]};
            delta_mag[i] = delta[i][mmcal_pkg::SUM_W-1] ? mmcal_pkg::SUM_W'(-delta[i])
                                                        : mmcal_pkg::SUM_W'(delta[i]);
            near[i]      = delta_mag[i] < {1'b0, limit_reg};
            span[i]      = {max_reg[i][mmcal_pkg::RAW_W-1], max_reg[i]}
                         - {min_reg[i][mmcal_pkg::RAW_W-1], min_reg[i]};
            psum[i]      = {max_reg[i][mmcal_pkg::RAW_W-1], max_reg[i]}
                         + {min_reg[i][mmcal_pkg::RAW_W-1], min_reg[i]};
            span_ok[i]   = !span[i][mmcal_pkg::SUM_W-1] && (span[i] != '0);
            num[i]       = {raw_in[i][mmcal_pkg::RAW_W-1], raw_in[i], 1'b0}
                         - {sum_reg[i][mmcal_pkg::SUM_W-1], sum_reg[i]};
            num_mag[i]   = num[i][mmcal_pkg::SUM_W] ? mmcal_pkg::SUM_W'(-num[i])
                                                    : mmcal_pkg::SUM_W'(num[i]);
            dividend[i]  = MAG_W'(num_mag[i]) << FRAC_BITS;
        end
    end

    assign steady   = &near;
    assign fail_now = !(&span_ok);

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        cal_active_next = cal_active_reg;
        ext_next        = ext_reg;
        fail_next       = fail_reg;
        limit_next      = limit_reg;
        last_next       = last_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        sum_next        = sum_reg;
        range_next      = range_reg;
        div_start       = 1'b0;
        load_res        = 1'b0;

        if (cfg_we)
        begin
            limit_next = cfg_wdata;
        end

        unique case (state_reg)
            mmcal_pkg::ST_IDLE:
            begin
                if (item.valid)
                begin
                    kind_next  = mmcal_pkg::KIND_ZERO;
                    ext_next   = 1'b0;
                    fail_next  = 1'b0;
                    state_next = mmcal_pkg::ST_DONE;
                    unique case (item.cmd)
                        mmcal_pkg::CMD_SAMPLE:
                        begin
                            last_next = raw_in;
                            if (cal_active_reg)
                            begin
                                kind_next = mmcal_pkg::KIND_RAW;
                                if (steady)
                                begin
                                    for (int i = 0; i < AX; i++)
                                    begin
                                        if (raw_in[i] < min_reg[i])
                                        begin
                                            min_next[i] = raw_in[i];
                                            ext_next    = 1'b1;
                                        end
                                        if (raw_in[i] > max_reg[i])
                                        begin
                                            max_next[i] = raw_in[i];
                                            ext_next    = 1'b1;
                                        end
                                    end
                                end
                            end
                            else
                            begin
                                kind_next  = mmcal_pkg::KIND_CORR;
                                div_start  = 1'b1;
                                state_next = mmcal_pkg::ST_DIV;
                            end
                        end
                        mmcal_pkg::CMD_START:
                        begin
                            cal_active_next = 1'b1;
                            for (int i = 0; i < AX; i++)
                            begin
                                min_next[i] = mmcal_pkg::MIN_RESET;
                                max_next[i] = mmcal_pkg::MAX_RESET;
                            end
                        end
                        mmcal_pkg::CMD_FINISH:
                        begin
                            // Finish outside calibration leaves the offsets and scales unchanged.
                            if (cal_active_reg)
                            begin
                                cal_active_next = 1'b0;
                                fail_next       = fail_now;
                                for (int i = 0; i < AX; i++)
                                begin
                                    sum_next[i]   = fail_now ? '0 : psum[i];
                                    range_next[i] = fail_now ? mmcal_pkg::RANGE_RESET
                                                             : span[i][mmcal_pkg::RANGE_W-1:0];
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            mmcal_pkg::ST_DIV:
            begin
                if (!(|div_busy))
                begin
                    state_next = mmcal_pkg::ST_DONE;
                end
            end
            mmcal_pkg::ST_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    load_res   = 1'b1;
                    state_next = mmcal_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmcal_pkg::ST_IDLE;
            end
        endcase
    end

    for (genvar g = 0; g < AX; g++)
    begin : g_div
        mmcal_div #(
            .DIVD_W (MAG_W)
        ) u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .start    (div_start),
            .dividend (dividend[g]),
            .divisor  (range_reg[g]),
            .busy     (div_busy[g]),
            .quotient (div_q[g])
        );
    end

    // Form the result fields; saturate the signed quotient to 32 bits.
    always_comb
    begin
        for (int i = 0; i < AX; i++)
        begin
            qx[i] = QX_W'(div_q[i]);
            case (kind_reg)
                mmcal_pkg::KIND_RAW:
                    corr_calc[i] = mmcal_pkg::OUT_W'(raw_hold_reg[i]) <<< FRAC_BITS;
                mmcal_pkg::KIND_CORR:
                begin
                    if (zero_reg[i])
                        corr_calc[i] = '0;
                    else if (neg_reg[i])
                        corr_calc[i] = (qx[i] > QX_W'(33'h0_8000_0000))
                                     ? 32'sh8000_0000 : mmcal_pkg::OUT_W'(-qx[i]);
                    else
                        corr_calc[i] = (qx[i] > QX_W'(32'h7FFF_FFFF))
                                     ? 32'sh7FFF_FFFF : mmcal_pkg::OUT_W'(qx[i]);
                end
                default:
                    corr_calc[i] = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mmcal_pkg::ST_IDLE;
            kind_reg       <= mmcal_pkg::KIND_ZERO;
            cal_active_reg <= 1'b0;
            ext_reg        <= 1'b0;
            fail_reg       <= 1'b0;
            limit_reg      <= mmcal_pkg::LIMIT_RESET;
            res_valid_reg  <= 1'b0;
            for (int i = 0; i < AX; i++)
            begin
                last_reg[i]  <= '0;
                min_reg[i]   <= mmcal_pkg::MIN_RESET;
                max_reg[i]   <= mmcal_pkg::MAX_RESET;
                sum_reg[i]   <= '0;
                range_reg[i] <= mmcal_pkg::RANGE_RESET;
            end
        end
        else
        begin
            state_reg      <= state_next;
            kind_reg       <= kind_next;
            cal_active_reg <= cal_active_next;
            ext_reg        <= ext_next;
            fail_reg       <= fail_next;
            limit_reg      <= limit_next;
            last_reg       <= last_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            sum_reg        <= sum_next;
            range_reg      <= range_next;
            if (load_res)
                res_valid_reg <= 1'b1;
            else if (result.ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < AX; i++)
            begin
                raw_hold_reg[i] <= raw_in[i];
                neg_reg[i]      <= num[i][mmcal_pkg::SUM_W];
                zero_reg[i]     <= (range_reg[i] == '0);
            end
        end
        if (load_res)
        begin
            corr_reg     <= corr_calc;
            ext_out_reg  <= ext_reg;
            cal_out_reg  <= cal_active_reg;
            fail_out_reg <= fail_reg;
        end
    end

    assign result.valid       = res_valid_reg;
    assign result.corrected_x = corr_reg[0];
    assign result.corrected_y = corr_reg[1];
    assign result.corrected_z = corr_reg[2];
    assign result.new_extreme = ext_out_reg;
    assign result.calibrating = cal_out_reg;
    assign result.cal_failed  = fail_out_reg;

`ifndef NO_ASSERTIONS
    a_div_only_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != mmcal_pkg::ST_DIV) |-> !(|div_busy))
        else $error("divider busy outside the divide state");

    a_div_launch: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |=> (state_reg == mmcal_pkg::ST_DIV) && (&div_busy))
        else $error("correction sample did not start all dividers");

    a_fail_ends_cal: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.cal_failed) |-> (!result.calibrating && !result.new_extreme))
        else $error("failed finish reported while calibrating");

    a_extreme_in_cal: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.new_extreme) |-> result.calibrating)
        else $error("new extreme reported outside calibration");

    a_range_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (range_reg[0] != '0) && (range_reg[1] != '0) && (range_reg[2] != '0))
        else $error("axis scale became zero");
`endif

endmodule
